// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the ring cache.
// Clock and reset are taken from the names clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define RSRC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define RSRC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- design/rsrc_pkg.sv -----
// Package of the rewindable stream ring cache: sizes, codes and the structs
// passed between the pointer unit, the ring memory and the output stage.
// No dependencies.
`timescale 1ns / 1ps

package rsrc_pkg;

   // Ring depth; a power of two so the ring index wraps by truncation.
   localparam int DEPTH    = 4096;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int POS_W    = 13;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 17;
   localparam int WHENCE_W = 2;
   // Seek sum: signed offset plus an unsigned position, with headroom.
   localparam int SEEK_W   = OFFSET_W + 2;

   localparam logic OP_READ = 1'b0;
   localparam logic OP_SEEK = 1'b1;

   localparam logic [WHENCE_W-1:0] WHENCE_ABS = 2'd0;
   localparam logic [WHENCE_W-1:0] WHENCE_CUR = 2'd1;
   localparam logic [WHENCE_W-1:0] WHENCE_END = 2'd2;

   typedef struct packed {
      logic                       operation;
      logic [WHENCE_W-1:0]        whence;
      logic signed [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]          upstream_byte;
      logic                       upstream_valid;
   } req_item_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] wdata;
   } mem_cmd_type;

   // Result of one item, less the byte of a cached read that the memory supplies.
   typedef struct packed {
      logic              from_ring;
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  fill_level;
   } rsp_info_type;

endpackage

// ----- design/rsrc_channels.sv -----
// Valid/ready channel interfaces of the ring cache: request and response.
// Depends on rsrc_pkg.
`timescale 1ns / 1ps

interface rsrc_req_if;
   import rsrc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [WHENCE_W-1:0]        whence;
   logic signed [OFFSET_W-1:0] offset;
   logic [BYTE_W-1:0]          upstream_byte;
   logic                       upstream_valid;

   modport source (output valid, operation, whence, offset, upstream_byte,
                   upstream_valid, input ready);
   modport sink (input valid, operation, whence, offset, upstream_byte,
                 upstream_valid, output ready);
endinterface

interface rsrc_rsp_if;
   import rsrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              data_valid;
   logic [POS_W-1:0]  position;
   logic [POS_W-1:0]  fill_level;

   modport source (output valid, data_byte, data_valid, position, fill_level,
                   input ready);
   modport sink (input valid, data_byte, data_valid, position, fill_level,
                 output ready);
endinterface

// ----- design/rewindable_stream_ring_cache.sv -----
// Rewindable stream ring cache: keeps the last DEPTH (4096) bytes of an upstream
// byte stream and replays them after a seek. Takes one request transaction per
// cycle while the response is not stalled; each result appears in the cycle after
// its request is accepted, when the registered read of the single-port ring
// memory returns. A stalled response holds the output register and the request
// side with it. Depends on rsrc_pkg, rsrc_channels, rsrc_ptr and rsrc_ring_mem.
`timescale 1ns / 1ps

module rewindable_stream_ring_cache (
   input  logic       clock,
   input  logic       reset,
   rsrc_req_if.sink   req_if,
   rsrc_rsp_if.source rsp_if
);
   import rsrc_pkg::*;

   logic              accept;
   req_item_type      req_item;
   mem_cmd_type       mem_cmd;
   rsp_info_type      rsp_info;
   logic [BYTE_W-1:0] rd_data;
   logic              out_valid_ff, out_valid_in;
   rsp_info_type      out_info_ff;

   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign req_item.operation      = req_if.operation;
   assign req_item.whence         = req_if.whence;
   assign req_item.offset         = req_if.offset;
   assign req_item.upstream_byte  = req_if.upstream_byte;
   assign req_item.upstream_valid = req_if.upstream_valid;

   rsrc_ptr u_ptr (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .mem_cmd  (mem_cmd),
      .rsp_info (rsp_info)
   );

   rsrc_ring_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   assign out_valid_in = accept || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_info_ff <= rsp_info;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.data_byte  = out_info_ff.from_ring ? rd_data : out_info_ff.data_byte;
   assign rsp_if.data_valid = out_info_ff.data_valid;
   assign rsp_if.position   = out_info_ff.position;
   assign rsp_if.fill_level = out_info_ff.fill_level;

endmodule

// ----- design/rsrc_ring_mem.sv -----
// Ring store of the cache: DEPTH bytes, one write or one registered read a cycle.
// Depends on rsrc_pkg.
`timescale 1ns / 1ps

module rsrc_ring_mem (
   input  logic                      clock,
   input  rsrc_pkg::mem_cmd_type     mem_cmd,
   output logic [rsrc_pkg::BYTE_W-1:0] rd_data
);
   import rsrc_pkg::*;

   logic [BYTE_W-1:0] ring_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         ring_mem[mem_cmd.addr] <= mem_cmd.wdata;
      end
   end

   // Hold the read data while the output stage is stalled.
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= ring_mem[mem_cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rsrc_ptr.sv -----
// Pointer unit of the ring cache: oldest index, read position and fill count,
// the read/seek decision, seek clamping and the ring memory command.
// Depends on rsrc_pkg.
`timescale 1ns / 1ps

module rsrc_ptr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  rsrc_pkg::req_item_type req_item,
   output rsrc_pkg::mem_cmd_type  mem_cmd,
   output rsrc_pkg::rsp_info_type rsp_info
);
   import rsrc_pkg::*;

   logic [IDX_W-1:0]         oldest_ff, oldest_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [POS_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         ring_idx;
   logic                     cached;
   logic                     full;
   logic signed [SEEK_W-1:0] offset_ext;
   logic signed [SEEK_W-1:0] base;
   logic signed [SEEK_W-1:0] target;
   logic signed [SEEK_W-1:0] upper;
   logic [POS_W-1:0]         seek_pos;

   // Wrap by truncation: DEPTH is a power of two.
   assign ring_idx = oldest_ff + pos_ff[IDX_W-1:0];
   assign cached   = pos_ff < fill_ff;
   assign full     = fill_ff == POS_W'(DEPTH);

   assign offset_ext = {{(SEEK_W-OFFSET_W){req_item.offset[OFFSET_W-1]}}, req_item.offset};

   always_comb begin
      case (req_item.whence)
         WHENCE_ABS: base = '0;
         WHENCE_CUR: base = {{(SEEK_W-POS_W){1'b0}}, pos_ff};
         WHENCE_END: base = {{(SEEK_W-POS_W){1'b0}}, fill_ff};
         default:    base = {{(SEEK_W-POS_W){1'b0}}, pos_ff};
      endcase
   end

   always_comb begin
      if (req_item.whence == WHENCE_ABS || req_item.whence == WHENCE_CUR ||
          req_item.whence == WHENCE_END) begin
         target = base + offset_ext;
      end else begin
         target = base;
      end
      // Clamp into the cached range; an empty cache pins to zero.
      if (fill_ff == '0) begin
         upper = '0;
      end else begin
         upper = {{(SEEK_W-POS_W){1'b0}}, fill_ff} - SEEK_W'(1);
      end
      if (target > upper) begin
         seek_pos = upper[POS_W-1:0];
      end else if (target < 0) begin
         seek_pos = '0;
      end else begin
         seek_pos = target[POS_W-1:0];
      end
   end

   always_comb begin
      oldest_in       = oldest_ff;
      pos_in          = pos_ff;
      fill_in         = fill_ff;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.rd_en   = 1'b0;
      mem_cmd.addr    = ring_idx;
      mem_cmd.wdata   = req_item.upstream_byte;
      rsp_info.from_ring  = 1'b0;
      rsp_info.data_byte  = '0;
      rsp_info.data_valid = 1'b0;
      if (req_item.operation == OP_READ) begin
         if (cached) begin
            mem_cmd.rd_en       = accept;
            rsp_info.from_ring  = 1'b1;
            rsp_info.data_valid = 1'b1;
            pos_in              = pos_ff + POS_W'(1);
         end else if (req_item.upstream_valid) begin
            mem_cmd.wr_en       = accept;
            rsp_info.data_byte  = req_item.upstream_byte;
            rsp_info.data_valid = 1'b1;
            if (full) begin
               // Overwrite the oldest byte and drop it.
               oldest_in = oldest_ff + IDX_W'(1);
            end else begin
               fill_in = fill_ff + POS_W'(1);
               pos_in  = pos_ff + POS_W'(1);
            end
         end
      end else begin
         pos_in = seek_pos;
      end
      rsp_info.position   = pos_in;
      rsp_info.fill_level = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         pos_ff    <= '0;
         fill_ff   <= '0;
      end else if (accept) begin
         oldest_ff <= oldest_in;
         pos_ff    <= pos_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- design/rsrc_checker.sv -----
// Port-level checks of the ring cache and the bind that attaches them.
// Depends on rsrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsrc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rsrc_pkg::BYTE_W-1:0] data_byte,
   input logic                        data_valid,
   input logic [rsrc_pkg::POS_W-1:0]  position,
   input logic [rsrc_pkg::POS_W-1:0]  fill_level
);
   import rsrc_pkg::*;

   `RSRC_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "response valid after reset")

   `RSRC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_byte) && $stable(data_valid) && $stable(position) && $stable(fill_level), "stalled response changed")

   `RSRC_ASSERT(a_one_cycle, req_valid && req_ready |=> rsp_valid, "no response one cycle after request")

   `RSRC_ASSERT(a_pos_range, rsp_valid |-> position <= fill_level && fill_level <= POS_W'(DEPTH), "position or fill level out of range")

   `RSRC_ASSERT(a_fill_grows, rsp_valid && rsp_ready |=> !rsp_valid || fill_level >= $past(fill_level), "fill level went down")

endmodule

bind rewindable_stream_ring_cache rsrc_checker u_rsrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .data_byte  (rsp_if.data_byte),
   .data_valid (rsp_if.data_valid),
   .position   (rsp_if.position),
   .fill_level (rsp_if.fill_level)
);
